// ----- hw/rtl/nmea_gga_position_parser_macros.svh -----
// Assertion macros used by the checker file of the position parser.
`ifndef NMEA_GGA_POSITION_PARSER_MACROS_SVH
`define NMEA_GGA_POSITION_PARSER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NGGA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NGGA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/ngga_pkg.sv -----
package ngga_pkg;

   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_DOT    = 8'h2E;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_G      = 8'h47;
   localparam logic [7:0] CHAR_N      = 8'h4E;
   localparam logic [7:0] CHAR_A      = 8'h41;
   localparam logic [7:0] CHAR_S      = 8'h53;
   localparam logic [7:0] CHAR_W      = 8'h57;

   localparam logic [2:0] HEADER_LEN = 3'd6;

   localparam logic [3:0] FIELD_LAT     = 4'd2;
   localparam logic [3:0] FIELD_LAT_DIR = 4'd3;
   localparam logic [3:0] FIELD_LON     = 4'd4;
   localparam logic [3:0] FIELD_LON_DIR = 4'd5;
   localparam logic [3:0] FIELD_MAX     = 4'd15;

   localparam logic [16:0] WHOLE_MAX = 17'd131071;

   // floor(w / 100) = (w * RECIP_100) >> 24 for every 17-bit w.
   localparam logic [17:0] RECIP_100 = 18'd167773;
   // floor(y / 3) = (y * RECIP_3) >> 21 for every y below 2^21.
   localparam logic [19:0] RECIP_3   = 20'd699051;
   localparam logic [33:0] DEG_SCALE = 34'd10000000;
   // Five thirds of 100000, whole part, for the minutes term.
   localparam logic [17:0] MIN_SCALE = 18'd166666;

   localparam logic [33:0] LAT_LIMIT = 34'd900000000;
   localparam logic [33:0] LON_LIMIT = 34'd1800000000;

   typedef struct packed {
      logic [16:0] whole;
      logic [16:0] frac;
      logic [2:0]  count;
      logic        in_frac;
      logic        neg;
   } coord_raw_type;

   typedef struct packed {
      coord_raw_type lat;
      coord_raw_type lon;
   } fix_type;

   typedef struct packed {
      logic [16:0] whole;
      logic [10:0] deg;
      logic [16:0] f5;
      logic        neg;
   } coord_s2_type;

   typedef struct packed {
      logic [6:0]  mm;
      logic [18:0] y;
      logic [33:0] degpart;
      logic        neg;
   } coord_s3_type;

   typedef struct packed {
      logic [17:0] q;
      logic [24:0] base;
      logic [33:0] degpart;
      logic        neg;
   } coord_s4_type;

   typedef struct packed {
      coord_s2_type lat;
      coord_s2_type lon;
   } s2_pair_type;

   typedef struct packed {
      coord_s3_type lat;
      coord_s3_type lon;
   } s3_pair_type;

   typedef struct packed {
      coord_s4_type lat;
      coord_s4_type lon;
   } s4_pair_type;

   function automatic logic [7:0] header_char(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0: ch = CHAR_DOLLAR;
         3'd1: ch = CHAR_G;
         3'd2: ch = CHAR_N;
         3'd3: ch = CHAR_G;
         3'd4: ch = CHAR_G;
         3'd5: ch = CHAR_A;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // Factor that brings a fraction of count digits to five digits.
   function automatic logic [16:0] frac_scale(input logic [2:0] count);
      logic [16:0] f;
      case (count)
         3'd0: f = 17'd100000;
         3'd1: f = 17'd10000;
         3'd2: f = 17'd1000;
         3'd3: f = 17'd100;
         3'd4: f = 17'd10;
         3'd5: f = 17'd1;
         default: f = 17'd0;
      endcase
      return f;
   endfunction

   function automatic coord_raw_type take_digit(input coord_raw_type cur,
                                                input logic [7:0] ch,
                                                input logic [2:0] frac_limit);
      coord_raw_type nxt;
      logic [20:0]   v;
      logic [3:0]    d;
      nxt = cur;
      d   = ch[3:0];
      v   = 21'(cur.whole) * 21'd10 + 21'(d);
      if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
         if (cur.in_frac) begin
            if (cur.count < frac_limit) begin
               nxt.frac  = 17'(cur.frac * 17'd10 + 17'(d));
               nxt.count = cur.count + 3'd1;
            end
         end else begin
            nxt.whole = (v > 21'(WHOLE_MAX)) ? WHOLE_MAX : v[16:0];
         end
      end else if (ch == CHAR_DOT) begin
         nxt.in_frac = 1'b1;
      end
      return nxt;
   endfunction

   function automatic coord_s2_type conv_stage2(input coord_raw_type r);
      coord_s2_type s;
      logic [34:0]  p_deg;
      logic [33:0]  p_frac;
      p_deg   = 35'(r.whole) * 35'(RECIP_100);
      p_frac  = 34'(r.frac) * 34'(frac_scale(r.count));
      s.whole = r.whole;
      s.deg   = p_deg[34:24];
      s.f5    = p_frac[16:0];
      s.neg   = r.neg;
      return s;
   endfunction

   function automatic coord_s3_type conv_stage3(input coord_s2_type r);
      coord_s3_type s;
      logic [16:0]  hundreds;
      hundreds  = 17'(17'(r.deg) * 17'd100);
      s.mm      = 7'(r.whole - hundreds);
      s.y       = 19'({s.mm, 1'b0}) + 19'(r.f5) * 19'd5;
      s.degpart = 34'(r.deg) * DEG_SCALE;
      s.neg     = r.neg;
      return s;
   endfunction

   function automatic coord_s4_type conv_stage4(input coord_s3_type r);
      coord_s4_type s;
      logic [38:0]  p_q;
      p_q       = 39'(r.y) * 39'(RECIP_3);
      s.q       = p_q[38:21];
      s.base    = 25'(r.mm) * 25'(MIN_SCALE);
      s.degpart = r.degpart;
      s.neg     = r.neg;
      return s;
   endfunction

   function automatic logic [31:0] conv_finish(input coord_s4_type r,
                                               input logic [33:0] limit);
      logic [33:0] mag;
      logic [33:0] sat;
      mag = r.degpart + 34'(r.base) + 34'(r.q);
      sat = (mag > limit) ? limit : mag;
      return r.neg ? (32'd0 - sat[31:0]) : sat[31:0];
   endfunction

endpackage

// ----- hw/rtl/ngga_parser.sv -----
module ngga_parser import ngga_pkg::*; #(
   parameter int LINE_MAX    = 99,
   parameter int FRAC_DIGITS = 5
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       byte_valid,
   input  logic [7:0] byte_data,
   output logic       fix_valid,
   output fix_type    fix
);

   localparam int LEN_W = $clog2(LINE_MAX + 1);
   localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LINE_MAX);
   localparam logic [2:0] FRAC_LIMIT = 3'(FRAC_DIGITS);

   logic [LEN_W-1:0] line_length_ff, line_length_in;
   logic [2:0]       match_count_ff, match_count_in;
   logic             matched_ff, matched_in;
   logic [3:0]       field_number_ff, field_number_in;
   logic             field_started_ff, field_started_in;
   coord_raw_type    lat_ff, lat_in;
   coord_raw_type    lon_ff, lon_in;

   always_comb begin
      line_length_in   = line_length_ff;
      match_count_in   = match_count_ff;
      matched_in       = matched_ff;
      field_number_in  = field_number_ff;
      field_started_in = field_started_ff;
      lat_in           = lat_ff;
      lon_in           = lon_ff;
      if (byte_valid) begin
         if (byte_data == CHAR_LF) begin
            line_length_in   = '0;
            match_count_in   = '0;
            matched_in       = 1'b0;
            field_number_in  = '0;
            field_started_in = 1'b0;
            lat_in           = '0;
            lon_in           = '0;
         end else if (line_length_ff < LEN_LIMIT) begin
            line_length_in = line_length_ff + LEN_W'(1);
            if (!matched_ff) begin
               if (byte_data == header_char(match_count_ff)) begin
                  match_count_in = match_count_ff + 3'd1;
               end else begin
                  match_count_in = (byte_data == CHAR_DOLLAR) ? 3'd1 : 3'd0;
               end
               if (match_count_in == HEADER_LEN) begin
                  matched_in     = 1'b1;
                  match_count_in = '0;
               end
            end
            if (byte_data == CHAR_COMMA) begin
               if (field_number_ff != FIELD_MAX) begin
                  field_number_in = field_number_ff + 4'd1;
               end
               field_started_in = 1'b0;
            end else begin
               case (field_number_ff)
                  FIELD_LAT: begin
                     lat_in = take_digit(lat_ff, byte_data, FRAC_LIMIT);
                  end
                  FIELD_LAT_DIR: begin
                     if (!field_started_ff) begin
                        lat_in.neg = (byte_data == CHAR_S);
                     end
                  end
                  FIELD_LON: begin
                     lon_in = take_digit(lon_ff, byte_data, FRAC_LIMIT);
                  end
                  FIELD_LON_DIR: begin
                     if (!field_started_ff) begin
                        lon_in.neg = (byte_data == CHAR_W);
                     end
                  end
                  default: begin
                  end
               endcase
               field_started_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff   <= '0;
         match_count_ff   <= '0;
         matched_ff       <= 1'b0;
         field_number_ff  <= '0;
         field_started_ff <= 1'b0;
         lat_ff           <= '0;
         lon_ff           <= '0;
      end else begin
         line_length_ff   <= line_length_in;
         match_count_ff   <= match_count_in;
         matched_ff       <= matched_in;
         field_number_ff  <= field_number_in;
         field_started_ff <= field_started_in;
         lat_ff           <= lat_in;
         lon_ff           <= lon_in;
      end
   end

   assign fix_valid = byte_valid && (byte_data == CHAR_LF) && matched_ff
                      && ((lat_ff.whole != '0) || (lat_ff.frac != '0))
                      && ((lon_ff.whole != '0) || (lon_ff.frac != '0));
   assign fix.lat   = lat_ff;
   assign fix.lon   = lon_ff;

endmodule

// ----- hw/rtl/ngga_conv.sv -----
module ngga_conv import ngga_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        fix_valid,
   input  fix_type     fix,
   output logic        fix_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [30:0] rsp_latitude,
   output logic [31:0] rsp_longitude
);

   logic        v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic        load1, load2, load3, load4, load5;
   fix_type     s1_ff;
   s2_pair_type s2_ff, s2_in;
   s3_pair_type s3_ff, s3_in;
   s4_pair_type s4_ff, s4_in;
   logic [31:0] lat_in, lon_in;
   logic [30:0] lat_ff;
   logic [31:0] lon_ff;

   // Each stage takes a new beat when it is empty or its successor moves on.
   assign load5 = !v5_ff || rsp_ready;
   assign load4 = !v4_ff || load5;
   assign load3 = !v3_ff || load4;
   assign load2 = !v2_ff || load3;
   assign load1 = !v1_ff || load2;

   assign s2_in.lat = conv_stage2(s1_ff.lat);
   assign s2_in.lon = conv_stage2(s1_ff.lon);
   assign s3_in.lat = conv_stage3(s2_ff.lat);
   assign s3_in.lon = conv_stage3(s2_ff.lon);
   assign s4_in.lat = conv_stage4(s3_ff.lat);
   assign s4_in.lon = conv_stage4(s3_ff.lon);
   assign lat_in    = conv_finish(s4_ff.lat, LAT_LIMIT);
   assign lon_in    = conv_finish(s4_ff.lon, LON_LIMIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (load1) begin
            v1_ff <= fix_valid;
         end
         if (load2) begin
            v2_ff <= v1_ff;
         end
         if (load3) begin
            v3_ff <= v2_ff;
         end
         if (load4) begin
            v4_ff <= v3_ff;
         end
         if (load5) begin
            v5_ff <= v4_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load1) begin
         s1_ff <= fix;
      end
      if (load2) begin
         s2_ff <= s2_in;
      end
      if (load3) begin
         s3_ff <= s3_in;
      end
      if (load4) begin
         s4_ff <= s4_in;
      end
      if (load5) begin
         lat_ff <= lat_in[30:0];
         lon_ff <= lon_in;
      end
   end

   assign fix_ready     = load1;
   assign rsp_valid     = v5_ff;
   assign rsp_latitude  = lat_ff;
   assign rsp_longitude = lon_ff;

endmodule

// ----- hw/rtl/nmea_gga_position_parser.sv -----
// NMEA GGA position parser.
// The req channel carries one received ASCII character per beat. Lines that
// contain the $GNGGA header are split on commas, and at the newline the
// latitude and longitude fields are converted to signed degrees in units of
// 1e-7 degree.
// The rsp channel carries one beat per qualifying line, latitude in the low
// 31 bits and longitude above it.
// A character is taken every cycle while the receiver keeps up. The result of
// a line reaches rsp through the four conversion stages and the output
// register after its newline beat is taken.
// The conversion stages close up bubbles, so the output register and four
// stages hold up to five results while rsp_tready is low; once they are all
// full, req_tready falls until the receiver takes a beat.
// Reset clears the line state and empties the conversion stages.
module nmea_gga_position_parser import ngga_pkg::*; #(
   parameter int LINE_MAX    = 99,
   parameter int FRAC_DIGITS = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // [30:0] latitude, [62:31] longitude, [63] zero
);

   logic        req_accept;
   logic        fix_valid;
   fix_type     fix;
   logic [30:0] latitude;
   logic [31:0] longitude;

   assign req_accept = req_tvalid && req_tready;

   ngga_parser #(
      .LINE_MAX    (LINE_MAX),
      .FRAC_DIGITS (FRAC_DIGITS)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_accept),
      .byte_data  (req_tdata),
      .fix_valid  (fix_valid),
      .fix        (fix)
   );

   ngga_conv u_conv (
      .clock         (clock),
      .reset         (reset),
      .fix_valid     (fix_valid),
      .fix           (fix),
      .fix_ready     (req_tready),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_latitude  (latitude),
      .rsp_longitude (longitude)
   );

   assign rsp_tdata = {1'b0, longitude, latitude};

endmodule

// ----- hw/rtl/nmea_gga_position_parser_checker.sv -----
`include "nmea_gga_position_parser_macros.svh"

module nmea_gga_position_parser_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);

   logic req_seen;

   assign req_seen = req_tvalid || (req_tdata != 8'h00);

   `NGGA_ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, !rsp_tvalid, "rsp valid right after reset")
   `NGGA_ASSERT_SAME(a_drain_frees_input, clock, reset, rsp_tready || !req_seen, req_tready || !rsp_tready, "input stalled while output drains")
   `NGGA_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled rsp beat changed")
   `NGGA_ASSERT_SAME(a_lat_range, clock, reset, rsp_tvalid, ($signed(rsp_tdata[30:0]) <= 32'sd900000000) && ($signed(rsp_tdata[30:0]) >= -32'sd900000000), "latitude out of range")
   `NGGA_ASSERT_SAME(a_lon_range, clock, reset, rsp_tvalid, ($signed(rsp_tdata[62:31]) <= 33'sd1800000000) && ($signed(rsp_tdata[62:31]) >= -33'sd1800000000) && !rsp_tdata[63], "longitude out of range")

endmodule

bind nmea_gga_position_parser nmea_gga_position_parser_checker u_checker (.*);

// ----- verif/nmea_gga_position_parser_tb.sv -----
module nmea_gga_position_parser_tb import ngga_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINE_LIMIT    = 99;
   localparam int FRAC_KEEP     = 5;
   localparam int HOLD_CYCLES   = 400;
   localparam int TOTAL_CHARS   = 1500;
   localparam int DRAIN_CYCLES  = 20;

   typedef struct packed {
      logic [30:0] lat;
      logic [31:0] lon;
   } position_t;

   typedef struct packed {
      logic [16:0] whole;
      logic [16:0] frac;
      logic [2:0]  count;
      logic        in_frac;
      logic        neg;
   } coord_acc_t;

   typedef struct {
      string text;
      int    pad;
      bit    typed;
      bit    emit;
      int    lat;
      int    lon;
   } stim_row_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;

   position_t   pending_fixes[$];
   logic [7:0]  sentence_buf[$];

   string       gga_tag = "$GNGGA";
   int          line_len;
   int          tag_run;
   bit          tag_seen;
   logic [3:0]  field_idx;
   bit          field_busy;
   coord_acc_t  lat_acc;
   coord_acc_t  lon_acc;

   int          mismatches;
   int          chars_sent;
   int          lines_sent;
   int          fixes_predicted;
   int          fixes_checked;
   int          burst_left;
   bit          sender_steady;
   bit          hold_requested;
   bit          hold_finished;
   int          hold_cycles;
   int          stall_mode;
   int          pattern_left;

   // A caret in a row stands for a NUL byte, and a bar for pad filler characters.
   localparam int NUM_ROWS = 24;
   stim_row_t stim_rows [NUM_ROWS] = '{
      '{"\n", 0, 1, 0, 0, 0},
      '{"$GNGGA,,4916.45,N,12311.12,W\n", 0, 1, 1, 492741666, -1231853333},
      '{"$GNGGA,,9999999,S,99999999,W\n", 0, 1, 1, -900000000, -1800000000},
      '{"$GNGGA,,0000.00000,N,00000.0,E\n", 0, 1, 0, 0, 0},
      '{"$GNGGA,,0.00001,N,0.1,E\n", 0, 1, 1, 1, 16666},
      '{"$GPGGA,,4916.45,N,12311.12,W\n", 0, 1, 0, 0, 0},
      '{"GNGGA,,4916,S,12311,W\n", 0, 1, 0, 0, 0},
      '{"$GNGGA,,4916.45,N,0,E\n", 0, 1, 0, 0, 0},
      '{"$GNGGA,,0,N,12311.12,W\n", 0, 1, 0, 0, 0},
      '{"$GNGGA,,.,N,.,E\n", 0, 1, 0, 0, 0},
      '{"xx$G$GNGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47\r\n",
        0, 0, 0, 0, 0},
      '{"$$GNGGA,,1234.5678901,S,00123.4567890123,E\n", 0, 0, 0, 0, 0},
      '{"$GNGGA,,1234.5,,12345.6,\n", 0, 0, 0, 0, 0},
      '{"$GNGGA,,+12^3.4.5e2 ,South,-98 76.54,West\n", 0, 0, 0, 0, 0},
      '{"$GNGGA,, 4916,s,12311,w\n", 0, 0, 0, 0, 0},
      '{"$GNGGA,,4916,NS, 12311,E W\n", 0, 0, 0, 0, 0},
      '{"$GNGGA,,4916, S,12311,\377W,\200\n", 0, 0, 0, 0, 0},
      '{"$GNGGA,,4916.45,N,12311.12,W|\n", 90, 0, 0, 0, 0},
      '{"$GNGGA,|,4916.45,N,12311.12,W\n", 85, 0, 0, 0, 0},
      '{"|$GNGGA,,1,,1\n", 95, 0, 0, 0, 0},
      '{"$GNGGA,,1,,1,,,,,,,,,,,,,,,,,,,7,8\n", 0, 0, 0, 0, 0},
      '{"$GNGGA,,999999999999.9999999,S,123456789012.99999,W\n", 0, 0, 0, 0, 0},
      '{"$GNGGA$GNGGA,,100,S,18000,W\n", 0, 0, 0, 0, 0},
      '{"$GNGGA,,0.0,S,99.99999,W\n", 0, 0, 0, 0, 0}
   };

   nmea_gga_position_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   function automatic void start_new_line();
      line_len   = 0;
      tag_run    = 0;
      tag_seen   = 1'b0;
      field_idx  = '0;
      field_busy = 1'b0;
      lat_acc    = '0;
      lon_acc    = '0;
   endfunction

   function automatic coord_acc_t accumulate_digit(coord_acc_t a, logic [7:0] c);
      int unsigned v;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         if (a.in_frac) begin
            if (a.count < FRAC_KEEP) begin
               a.frac  = 17'(int'(a.frac) * 10 + int'(c - CHAR_ZERO));
               a.count = a.count + 3'd1;
            end
         end else begin
            v = int'(a.whole) * 10 + int'(c - CHAR_ZERO);
            a.whole = (v > int'(WHOLE_MAX)) ? WHOLE_MAX : 17'(v);
         end
      end else if (c == CHAR_DOT) begin
         a.in_frac = 1'b1;
      end
      return a;
   endfunction

   function automatic logic [31:0] scaled_degrees(coord_acc_t a, longint unsigned limit);
      longint unsigned scale;
      longint unsigned minutes;
      longint unsigned mag;
      scale = 1;
      for (int k = 0; k < int'(a.count); k++) scale = scale * 10;
      minutes = longint'(a.whole % 17'd100) * scale + longint'(a.frac);
      mag = longint'(a.whole / 17'd100) * 64'd10000000
            + (minutes * 64'd10000000) / (64'd60 * scale);
      if (mag > limit) mag = limit;
      return a.neg ? 32'(64'd0 - mag) : 32'(mag);
   endfunction

   // Advances the line state by one character and reports a position at a newline.
   function automatic bit parse_char(logic [7:0] c, output position_t fix);
      bit emit;
      fix = '0;
      if (c == CHAR_LF) begin
         emit = tag_seen && (lat_acc.whole != 0 || lat_acc.frac != 0)
                && (lon_acc.whole != 0 || lon_acc.frac != 0);
         if (emit) begin
            fix.lat = 31'(scaled_degrees(lat_acc, longint'(LAT_LIMIT)));
            fix.lon = scaled_degrees(lon_acc, longint'(LON_LIMIT));
         end
         start_new_line();
         return emit;
      end
      if (line_len >= LINE_LIMIT) return 1'b0;
      line_len++;
      if (!tag_seen) begin
         if (c == gga_tag[tag_run]) tag_run++;
         else tag_run = (c == CHAR_DOLLAR) ? 1 : 0;
         if (tag_run >= int'(HEADER_LEN)) begin
            tag_seen = 1'b1;
            tag_run  = 0;
         end
      end
      if (c == CHAR_COMMA) begin
         if (field_idx < FIELD_MAX) field_idx = field_idx + 4'd1;
         field_busy = 1'b0;
         return 1'b0;
      end
      case (field_idx)
         FIELD_LAT:     lat_acc = accumulate_digit(lat_acc, c);
         FIELD_LAT_DIR: if (!field_busy) lat_acc.neg = (c == CHAR_S);
         FIELD_LON:     lon_acc = accumulate_digit(lon_acc, c);
         FIELD_LON_DIR: if (!field_busy) lon_acc.neg = (c == CHAR_W);
         default: ;
      endcase
      field_busy = 1'b1;
      return 1'b0;
   endfunction

   function automatic void report_mismatch(string what, longint want, longint got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
   endfunction

   task automatic send_char(input logic [7:0] c, input bit typed = 1'b0,
                            input bit typed_emit = 1'b0, input position_t typed_fix = '0);
      position_t fix;
      bit        emit;
      int        gap;
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      chars_sent++;
      emit = parse_char(c, fix);
      if (typed && c == CHAR_LF) begin
         emit = typed_emit;
         fix  = typed_fix;
      end
      if (emit) begin
         pending_fixes.push_back(fix);
         fixes_predicted++;
      end
      if (c == CHAR_LF) lines_sent++;
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else if (!sender_steady) begin
         gap = $urandom_range(1, 8);
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom);
         repeat (gap) @(negedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(0, 20);
      end
   endtask

   task automatic send_row(input stim_row_t row);
      position_t typed_fix;
      logic [7:0] c;
      typed_fix.lat = 31'(row.lat);
      typed_fix.lon = 32'(row.lon);
      for (int i = 0; i < row.text.len(); i++) begin
         c = row.text[i];
         if (c == "|") begin
            repeat (row.pad) send_char("x");
         end else if (c == "^") begin
            send_char(8'h00);
         end else begin
            send_char(c, row.typed, row.emit, typed_fix);
         end
      end
   endtask

   task automatic send_buffer();
      while (sentence_buf.size() > 0) send_char(sentence_buf.pop_front());
   endtask

   function automatic void push_text(string s);
      for (int i = 0; i < s.len(); i++) sentence_buf.push_back(s[i]);
   endfunction

   function automatic logic [7:0] printable_junk();
      logic [7:0] c;
      c = 8'($urandom_range(8'h20, 8'h7E));
      return (c == CHAR_COMMA) ? 8'h2B : c;
   endfunction

   function automatic void push_coord(int typical_whole);
      int n_whole;
      int n_frac;
      n_whole = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : typical_whole;
      n_frac  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : FRAC_KEEP;
      repeat (n_whole) sentence_buf.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
      if ($urandom_range(0, 9) != 0) sentence_buf.push_back(CHAR_DOT);
      repeat (n_frac) sentence_buf.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
      if ($urandom_range(0, 9) == 0)
         sentence_buf.insert($urandom_range(0, sentence_buf.size()), printable_junk());
   endfunction

   function automatic void push_direction(logic [7:0] plain, logic [7:0] flipped);
      case ($urandom_range(0, 7))
         0:       ;
         1:       sentence_buf.push_back(plain | 8'h20);
         2:       sentence_buf.push_back(printable_junk());
         3:       push_text("Sx");
         4, 5:    sentence_buf.push_back(flipped);
         default: sentence_buf.push_back(plain);
      endcase
   endfunction

   // Builds one random line; returns 1 when it is noise rather than a sentence.
   function automatic bit build_random_line();
      int kind;
      int cut;
      kind = $urandom_range(0, 19);
      if (kind < 3) begin
         repeat ($urandom_range(1, 60)) sentence_buf.push_back(8'($urandom_range(0, 255)));
         sentence_buf.push_back(CHAR_LF);
         return 1'b1;
      end
      if ($urandom_range(0, 9) == 0)
         repeat ($urandom_range(1, 4)) sentence_buf.push_back(printable_junk());
      case ($urandom_range(0, 19))
         0:       push_text("$GPGGA");
         1:       push_text("$GNGG");
         2:       push_text("$GNGSA");
         default: push_text("$GNGGA");
      endcase
      push_text(",");
      if ($urandom_range(0, 1)) push_text($sformatf("%06d", $urandom_range(0, 235959)));
      push_text(",");
      push_coord(4);
      push_text(",");
      push_direction(CHAR_N, CHAR_S);
      push_text(",");
      push_coord(5);
      push_text(",");
      push_direction(8'h45, CHAR_W);
      if ($urandom_range(0, 1)) push_text(",1,08,0.9,545.4,M,46.9,M,,*47");
      if ($urandom_range(0, 19) == 0) repeat ($urandom_range(60, 80)) push_text("x");
      if ($urandom_range(0, 3) == 0) push_text("\r");
      if (kind < 6) begin
         cut = $urandom_range(0, sentence_buf.size() - 1);
         if ($urandom_range(0, 1)) begin
            while (sentence_buf.size() > cut) void'(sentence_buf.pop_back());
         end else begin
            sentence_buf[cut] = 8'($urandom_range(0, 255));
            if (sentence_buf[cut] == CHAR_LF) sentence_buf[cut] = CHAR_DOLLAR;
         end
      end
      sentence_buf.push_back(CHAR_LF);
      return 1'b0;
   endfunction

   always @(posedge clock) begin
      position_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_fixes.size() == 0) begin
            report_mismatch("unexpected beat, longitude", 0, longint'($signed(rsp_tdata[62:31])));
         end else begin
            want = pending_fixes.pop_front();
            fixes_checked++;
            if (rsp_tdata[30:0] !== want.lat)
               report_mismatch("latitude", longint'($signed(want.lat)),
                               longint'($signed(rsp_tdata[30:0])));
            if (rsp_tdata[62:31] !== want.lon)
               report_mismatch("longitude", longint'($signed(want.lon)),
                               longint'($signed(rsp_tdata[62:31])));
            if (rsp_tdata[63] !== 1'b0)
               report_mismatch("padding bit", 0, longint'(rsp_tdata[63]));
         end
      end
   end

   // The receiver stalls on a changing pattern, with one long hold while the input backs up.
   initial begin
      forever begin
         if (hold_requested && !hold_finished) begin
            rsp_tready <= 1'b0;
            for (hold_cycles = 0; hold_cycles < HOLD_CYCLES; hold_cycles++) @(negedge clock);
            hold_finished = 1'b1;
         end else begin
            if (pattern_left == 0) begin
               stall_mode   = $urandom_range(0, 2);
               pattern_left = $urandom_range(20, 200);
            end
            pattern_left--;
            case (stall_mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= 1'($urandom_range(0, 1));
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
            @(negedge clock);
         end
      end
   end

   initial begin
      #1_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      start_new_line();
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      foreach (stim_rows[r]) send_row(stim_rows[r]);

      sender_steady  = 1'b1;
      hold_requested = 1'b1;
      repeat (8) begin
         push_text($sformatf("$GNGGA,,%0d,S,%0d,W\n", $urandom_range(1, 99999),
                             $urandom_range(1, 999999)));
         send_buffer();
      end
      sender_steady = 1'b0;

      while (chars_sent < TOTAL_CHARS) begin
         void'(build_random_line());
         send_buffer();
      end
      req_tvalid <= 1'b0;

      while (pending_fixes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Parsed %0d characters in %0d lines, including long, broken and noisy lines.",
               chars_sent, lines_sent);
      $display("Checked %0d positions, with a %0d-cycle receiver hold that backed up the input.",
               fixes_checked, HOLD_CYCLES);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/ngga_pkg.sv
hw/rtl/ngga_parser.sv
hw/rtl/ngga_conv.sv
hw/rtl/nmea_gga_position_parser.sv
hw/rtl/nmea_gga_position_parser_checker.sv
verif/nmea_gga_position_parser_tb.sv
